[design/cholesky_upper_factorization_unit_defines.svh]
// assertion macros shared by the design files
`ifndef CHOLESKY_UPPER_FACTORIZATION_UNIT_DEFINES_SVH
`define CHOLESKY_UPPER_FACTORIZATION_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CHOL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CHOL_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CHOL_ASSERT(lbl, clk, rstn, prop, msg)
`define CHOL_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[design/chol_pkg.sv]
`timescale 1ns / 1ps
package chol_pkg;
  localparam int unsigned MAX_SIZE_DEF = 8;
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_NPD = 2'd1;
  localparam status_t ST_SAT = 2'd2;

  typedef enum logic [3:0] {
    B_IDLE,
    B_KADDR,
    B_KMUL,
    B_KACC,
    B_FADDR,
    B_FDATA,
    B_SQRT,
    B_PWR,
    B_DIV,
    B_DFIN,
    B_OADDR,
    B_OLOAD,
    B_OWAIT
  } back_state_t;
endpackage

[design/chol_ram.sv]
`timescale 1ns / 1ps
module chol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[design/chol_front.sv]
`timescale 1ns / 1ps
module chol_front #(
  parameter int unsigned MAX_SIZE = chol_pkg::MAX_SIZE_DEF,
  localparam int unsigned IW = $clog2(MAX_SIZE + 1),
  localparam int unsigned AW = (MAX_SIZE * MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1,
  localparam int unsigned QW = chol_pkg::DATA_W + 2 + AW
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [chol_pkg::DATA_W-1:0] in_element_value,
  input  logic                       in_last_element,
  input  logic [IW-1:0]              size_n,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [QW-1:0]              push_data
);
  logic [IW-1:0] row_r, row_nxt;
  logic [IW-1:0] col_r, col_nxt;
  logic          accept;
  logic          wr;
  logic [AW-1:0] addr;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;
  assign wr         = (row_r < size_n);
  assign addr       = AW'(row_r * MAX_SIZE + col_r);
  assign push_data  = {in_element_value, in_last_element, wr, addr};

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (in_last_element) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (wr) begin
        if (col_r == size_n - IW'(1)) begin
          col_nxt = '0;
          row_nxt = row_r + IW'(1);
        end else begin
          col_nxt = col_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end
endmodule

[design/chol_queue.sv]
`timescale 1ns / 1ps
`include "cholesky_upper_factorization_unit_defines.svh"
module chol_queue #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = chol_pkg::QUEUE_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign push_fire  = push_valid & push_ready;
  assign pop_fire   = pop_valid & pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push_fire) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop_fire) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + CW'(1);
    end else if (!push_fire && pop_fire) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  `CHOL_ASSERT(a_queue_fill, clk, rst_n, (push_fire && !pop_fire) |=> (count_r == $past(count_r) + CW'(1)), "queue count did not grow on push")
  `CHOL_ASSERT_NEVER(a_queue_over, clk, rst_n, count_r > CW'(DEPTH), "queue count above depth")
endmodule

[design/chol_back.sv]
`timescale 1ns / 1ps
`include "cholesky_upper_factorization_unit_defines.svh"
module chol_back #(
  parameter int unsigned MAX_SIZE = chol_pkg::MAX_SIZE_DEF,
  localparam int unsigned IW = $clog2(MAX_SIZE + 1),
  localparam int unsigned AW = (MAX_SIZE * MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1,
  localparam int unsigned QW = chol_pkg::DATA_W + 2 + AW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [IW-1:0]               size_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  logic [QW-1:0]               pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [chol_pkg::DATA_W-1:0] out_factor_value,
  output chol_pkg::status_t           out_status,
  output logic                        out_last_result
);
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if ((a[63] != b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  chol_pkg::back_state_t state_r, state_nxt;

  logic [31:0]        q_value;
  logic               q_last, q_wr;
  logic [AW-1:0]      q_addr;

  logic [IW-1:0]      j_r, row_r, k_r;
  logic               diag_r, sat_r, fail_r, neg_r, num_zero_r;
  logic signed [63:0] acc_r, prod_r;
  logic [31:0]        piv_r, rem_r;
  logic [63:0]        x_r, res_r, bit_r, quo_r;
  logic [5:0]         cnt_r;

  logic               out_valid_r, out_last_r;
  logic [31:0]        out_value_r;
  chol_pkg::status_t  out_status_r;

  logic               we;
  logic [AW-1:0]      waddr, raddr_a, raddr_b;
  logic [31:0]        wdata, rdata_a, rdata_b;

  logic signed [63:0] dd, num, num_abs;
  logic               not_pd;
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic [32:0]        rem_try, rem_diff;
  logic               dv_ge;
  logic [31:0]        q_val;
  logic               q_sat;
  logic               last_k, col_done;

  assign {q_value, q_last, q_wr, q_addr} = pop_data;

  chol_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_ram_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_a), .rdata(rdata_a)
  );
  chol_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_b), .rdata(rdata_b)
  );

  assign dd       = {{16{rdata_a[31]}}, rdata_a, 16'b0};
  assign not_pd   = (acc_r > dd);
  assign num      = sat_sub(dd, acc_r);
  assign num_abs  = num[63] ? -num : num;
  assign sq_t     = res_r + bit_r;
  assign sq_ge    = (x_r >= sq_t);
  assign rem_try  = {rem_r, quo_r[63]};
  assign rem_diff = rem_try - {1'b0, piv_r};
  assign dv_ge    = (rem_try >= {1'b0, piv_r});
  assign last_k   = (k_r == size_n - IW'(1));
  assign col_done = (row_r + IW'(1) >= j_r);

  always_comb begin
    q_sat = 1'b0;
    q_val = quo_r[31:0];
    if (num_zero_r) begin
      q_val = '0;
    end else if (neg_r) begin
      if (quo_r > 64'h0000_0000_8000_0000) begin
        q_sat = 1'b1;
        q_val = 32'h8000_0000;
      end else begin
        q_val = 32'(-quo_r[31:0]);
      end
    end else if (quo_r > 64'h0000_0000_7fff_ffff) begin
      q_sat = 1'b1;
      q_val = 32'h7fff_ffff;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chol_pkg::B_IDLE:  if (pop_valid && q_last) state_nxt = chol_pkg::B_KADDR;
      chol_pkg::B_KADDR: state_nxt = (k_r < size_n) ? chol_pkg::B_KMUL : chol_pkg::B_FADDR;
      chol_pkg::B_KMUL:  state_nxt = chol_pkg::B_KACC;
      chol_pkg::B_KACC:  state_nxt = chol_pkg::B_KADDR;
      chol_pkg::B_FADDR: state_nxt = chol_pkg::B_FDATA;
      chol_pkg::B_FDATA: begin
        if (!diag_r) state_nxt = chol_pkg::B_DIV;
        else if (not_pd) state_nxt = chol_pkg::B_OLOAD;
        else state_nxt = chol_pkg::B_SQRT;
      end
      chol_pkg::B_SQRT:  if (cnt_r == 6'd31) state_nxt = chol_pkg::B_PWR;
      chol_pkg::B_PWR:   state_nxt = (j_r != '0) ? chol_pkg::B_KADDR : chol_pkg::B_OADDR;
      chol_pkg::B_DIV:   if (cnt_r == 6'd63) state_nxt = chol_pkg::B_DFIN;
      chol_pkg::B_DFIN:  state_nxt = chol_pkg::B_KADDR;
      chol_pkg::B_OADDR: state_nxt = chol_pkg::B_OLOAD;
      chol_pkg::B_OLOAD: state_nxt = chol_pkg::B_OWAIT;
      chol_pkg::B_OWAIT: begin
        if (out_ready) state_nxt = out_last_r ? chol_pkg::B_IDLE : chol_pkg::B_OADDR;
      end
      default:           state_nxt = chol_pkg::B_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    pop_ready = 1'b0;
    we        = 1'b0;
    waddr     = q_addr;
    wdata     = q_value;
    raddr_a   = AW'(row_r * MAX_SIZE + k_r);
    raddr_b   = AW'(j_r * MAX_SIZE + k_r);
    unique case (state_r)
      chol_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        we        = pop_valid & q_wr;
      end
      chol_pkg::B_FADDR: raddr_a = AW'(row_r * MAX_SIZE + j_r);
      chol_pkg::B_PWR: begin
        we    = 1'b1;
        waddr = AW'(j_r * MAX_SIZE + j_r);
        wdata = res_r[31:0];
      end
      chol_pkg::B_DFIN: begin
        we    = 1'b1;
        waddr = AW'(row_r * MAX_SIZE + j_r);
        wdata = q_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      chol_pkg::B_IDLE: begin
        j_r    <= size_n - IW'(1);
        row_r  <= size_n - IW'(1);
        k_r    <= size_n;
        acc_r  <= '0;
        diag_r <= 1'b1;
      end
      chol_pkg::B_KMUL: prod_r <= $signed(rdata_a) * $signed(rdata_b);
      chol_pkg::B_KACC: begin
        acc_r <= sat_add(acc_r, prod_r);
        k_r   <= k_r + IW'(1);
      end
      chol_pkg::B_FDATA: begin
        x_r        <= 64'(dd - acc_r);
        res_r      <= '0;
        bit_r      <= 64'h4000_0000_0000_0000;
        quo_r      <= num_abs;
        neg_r      <= num[63];
        num_zero_r <= (num == '0);
        rem_r      <= '0;
        cnt_r      <= '0;
      end
      chol_pkg::B_SQRT: begin
        if (sq_ge) begin
          x_r   <= x_r - sq_t;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 6'd1;
      end
      chol_pkg::B_PWR: begin
        piv_r  <= res_r[31:0];
        row_r  <= '0;
        k_r    <= (j_r == '0) ? '0 : j_r + IW'(1);
        acc_r  <= '0;
        diag_r <= 1'b0;
      end
      chol_pkg::B_DIV: begin
        rem_r <= dv_ge ? rem_diff[31:0] : rem_try[31:0];
        quo_r <= {quo_r[62:0], dv_ge};
        cnt_r <= cnt_r + 6'd1;
      end
      chol_pkg::B_DFIN: begin
        acc_r <= '0;
        if (col_done) begin
          j_r    <= j_r - IW'(1);
          row_r  <= j_r - IW'(1);
          k_r    <= j_r;
          diag_r <= 1'b1;
        end else begin
          row_r <= row_r + IW'(1);
          k_r   <= j_r + IW'(1);
        end
      end
      chol_pkg::B_OLOAD: begin
        if (fail_r || (diag_r && not_pd && state_r == chol_pkg::B_FDATA)) begin
          out_value_r  <= '0;
        end else begin
          out_value_r  <= (k_r >= row_r) ? rdata_a : '0;
        end
        out_status_r <= fail_r ? chol_pkg::ST_NPD : (sat_r ? chol_pkg::ST_SAT : chol_pkg::ST_OK);
        out_last_r   <= fail_r || ((row_r == size_n - IW'(1)) && last_k);
      end
      chol_pkg::B_OWAIT: begin
        if (out_ready) begin
          if (last_k) begin
            k_r   <= '0;
            row_r <= row_r + IW'(1);
          end else begin
            k_r <= k_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chol_pkg::B_IDLE;
      sat_r       <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == chol_pkg::B_DFIN && q_sat) begin
        sat_r <= 1'b1;
      end
      if (state_r == chol_pkg::B_FDATA && diag_r && not_pd) begin
        fail_r <= 1'b1;
      end
      if (state_r == chol_pkg::B_OLOAD) begin
        out_valid_r <= 1'b1;
      end else if (state_r == chol_pkg::B_OWAIT && out_ready) begin
        out_valid_r <= 1'b0;
        if (out_last_r) begin
          sat_r  <= 1'b0;
          fail_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_factor_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_last_result  = out_last_r;

  `CHOL_ASSERT(a_out_state, clk, rst_n, out_valid_r |-> (state_r == chol_pkg::B_OWAIT), "result shown outside output wait")
  `CHOL_ASSERT(a_npd_last, clk, rst_n, (out_valid_r && (out_status_r == chol_pkg::ST_NPD)) |-> out_last_r, "error result not marked last")
  `CHOL_ASSERT(a_run_start, clk, rst_n, ((state_r == chol_pkg::B_IDLE) && pop_valid && q_last) |=> (state_r == chol_pkg::B_KADDR), "factorisation did not start on last request")
endmodule

[design/cholesky_upper_factorization_unit.sv]
`timescale 1ns / 1ps
// Upper Cholesky factoriser, A = U*U^T, signed Q16.16. Elements of an n by n
// matrix (n from cfg_wdata, clamped to 1..MAX_SIZE) enter row-major, one per
// cycle while the queue has room, through a two-entry request queue into a
// stored copy of the matrix. The request flagged last starts the
// factorisation, worked column by column from the last one, with one shared
// 32x32 multiplier (address, multiply and accumulate states per product term),
// a 32-step square root per pivot and a 64-step divider per entry above the
// pivot. Then U is read out row-major, n*n results, lower triangle zero, or
// one error result with status 1 if a radicand is negative (not positive
// definite). Status 2 on every result marks a saturated quotient in the run.
module cholesky_upper_factorization_unit #(
  parameter int unsigned MAX_SIZE = chol_pkg::MAX_SIZE_DEF,
  localparam int unsigned IW = $clog2(MAX_SIZE + 1),
  localparam int unsigned AW = (MAX_SIZE * MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1,
  localparam int unsigned QW = chol_pkg::DATA_W + 2 + AW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [chol_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [chol_pkg::DATA_W-1:0] in_element_value,
  input  logic                         in_last_element,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [chol_pkg::DATA_W-1:0] out_factor_value,
  output logic [1:0]                   out_status,
  output logic                         out_last_result
);
  logic [chol_pkg::CFG_W-1:0] size_r, size_nxt;
  logic [IW-1:0]              size_n;
  logic                       push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]              push_data, pop_data;
  logic [chol_pkg::DATA_W-1:0] factor;
  chol_pkg::status_t          status;

  assign size_nxt = cfg_we ? cfg_wdata : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= chol_pkg::SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  always_comb begin
    if (size_r == '0) begin
      size_n = IW'(1);
    end else if (size_r > chol_pkg::CFG_W'(MAX_SIZE)) begin
      size_n = IW'(MAX_SIZE);
    end else begin
      size_n = IW'(size_r);
    end
  end

  chol_front #(.MAX_SIZE(MAX_SIZE)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_element_value(in_element_value), .in_last_element(in_last_element),
    .size_n(size_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  chol_queue #(.WIDTH(QW), .DEPTH(chol_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  chol_back #(.MAX_SIZE(MAX_SIZE)) u_back (
    .clk(clk), .rst_n(rst_n), .size_n(size_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_factor_value(factor), .out_status(status), .out_last_result(out_last_result)
  );

  assign out_factor_value = $signed(factor);
  assign out_status       = status;
endmodule
